[rtl/core/bdlp_pkg.sv]
// Shared constants and types for the button debounce / long-press block.
package bdlp_pkg;

  localparam int BTN_COUNT = 3;
  localparam int HOLD_W    = 16;
  localparam int IDX_W     = 8;
  localparam int BTN_IDX_W = (BTN_COUNT > 1) ? $clog2(BTN_COUNT) : 1;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(100);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  operation;
    logic [BTN_COUNT-1:0] raw_levels;
    logic [IDX_W-1:0]     button_index;
  } item_t;

  typedef struct packed {
    logic [BTN_COUNT-1:0] pressed_levels;
    logic [BTN_COUNT-1:0] long_held;
    logic                 edge_seen;
  } result_t;

endpackage

[rtl/core/bdlp_if.sv]
// Valid/ready channel interfaces for the input items and the results.
interface bdlp_in_if
  import bdlp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  op_t                  operation;
  logic [BTN_COUNT-1:0] raw_levels;
  logic [IDX_W-1:0]     button_index;

  modport source (output valid, output operation, output raw_levels,
                  output button_index, input ready);
  modport sink   (input valid, input operation, input raw_levels,
                  input button_index, output ready);
endinterface

interface bdlp_out_if
  import bdlp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BTN_COUNT-1:0] pressed_levels;
  logic [BTN_COUNT-1:0] long_held;
  logic                 edge_seen;

  modport source (output valid, output pressed_levels, output long_held,
                  output edge_seen, input ready);
  modport sink   (input valid, input pressed_levels, input long_held,
                  input edge_seen, output ready);
endinterface

[rtl/core/button_debounce_long_press_edge.sv]
// Top level: input register, state update, result register.
// The input item is held in the input register until the state update can step, and its
// result is then held in the result register until the output takes it.
// Throughput: one transaction per cycle; the input register advances whenever
// the result register is empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): all levels released, counters and flags
// cleared, hold limit back to 100, both pipeline registers empty.
module button_debounce_long_press_edge
  import bdlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bdlp_in_if.sink           in_ch,
  bdlp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    adv;
  logic    in_take;

  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || adv;

  bdlp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (s1_item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation    <= in_ch.operation;
      s1_item_r.raw_levels   <= in_ch.raw_levels;
      s1_item_r.button_index <= in_ch.button_index;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pressed_levels = out_res_r.pressed_levels;
  assign out_ch.long_held      = out_res_r.long_held;
  assign out_ch.edge_seen      = out_res_r.edge_seen;

endmodule

[rtl/core/bdlp_engine.sv]
// Button state: sample history, stable levels, hold counters, edge tracking.
module bdlp_engine
  import bdlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  item_t             item,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata,
  output result_t           res
);

  // level vectors: 1 = released
  logic [BTN_COUNT-1:0] newer_r, newer_nxt;
  logic [BTN_COUNT-1:0] older_r, older_nxt;
  logic [BTN_COUNT-1:0] stable_r, stable_nxt;
  logic [BTN_COUNT-1:0] edge_last_r, edge_last_nxt;
  logic [BTN_COUNT-1:0] hold_flag_r, hold_flag_nxt;
  logic [HOLD_W-1:0]    hold_cnt_r [BTN_COUNT];
  logic [HOLD_W-1:0]    hold_cnt_nxt [BTN_COUNT];
  logic [HOLD_W-1:0]    hold_ticks_r;
  logic                 edge_hit;

  always_comb begin
    logic [BTN_IDX_W-1:0] sel;
    logic                 in_range;
    newer_nxt     = newer_r;
    older_nxt     = older_r;
    stable_nxt    = stable_r;
    edge_last_nxt = edge_last_r;
    hold_flag_nxt = hold_flag_r;
    hold_cnt_nxt  = hold_cnt_r;
    edge_hit      = 1'b0;
    sel           = item.button_index[BTN_IDX_W-1:0];
    in_range      = (item.button_index < IDX_W'(BTN_COUNT));

    if (item.operation == OP_TICK) begin
      older_nxt = newer_r;
      newer_nxt = item.raw_levels;
      for (int i = 0; i < BTN_COUNT; i++) begin
        if (item.raw_levels[i] == newer_r[i]) begin
          stable_nxt[i] = item.raw_levels[i];
        end
        if (!stable_nxt[i]) begin
          if (hold_cnt_r[i] < hold_ticks_r) begin
            hold_cnt_nxt[i] = hold_cnt_r[i] + HOLD_W'(1);
          end else begin
            hold_flag_nxt[i] = 1'b1;
          end
        end else begin
          hold_cnt_nxt[i]  = '0;
          hold_flag_nxt[i] = 1'b0;
        end
      end
    end else if (in_range) begin
      if (!stable_r[sel] && edge_last_r[sel]) begin
        edge_last_nxt[sel] = 1'b0;
        edge_hit           = 1'b1;
      end else if (stable_r[sel]) begin
        edge_last_nxt[sel] = 1'b1;
      end
    end
  end

  assign res.pressed_levels = ~stable_nxt;
  assign res.long_held      = hold_flag_nxt;
  assign res.edge_seen      = edge_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newer_r      <= '1;
      older_r      <= '1;
      stable_r     <= '1;
      edge_last_r  <= '1;
      hold_flag_r  <= '0;
      hold_ticks_r <= HOLD_TICKS_RST;
      for (int i = 0; i < BTN_COUNT; i++) begin
        hold_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        hold_ticks_r <= cfg_wdata;
      end
      if (step) begin
        newer_r     <= newer_nxt;
        older_r     <= older_nxt;
        stable_r    <= stable_nxt;
        edge_last_r <= edge_last_nxt;
        hold_flag_r <= hold_flag_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
      end
    end
  end

endmodule
